// ===== sv/fixed_partition_fit_allocator_core_defines.svh =====
// Assertion macros used by the checker of the partition allocator.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPFA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpfa check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpfa check failed");

`endif

// ===== sv/fpfa_pkg.sv =====
`timescale 1ns / 1ps

package fpfa_pkg;

   localparam int NUM_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;
   localparam int IDX_BITS       = $clog2(NUM_PARTITIONS);
   localparam int CNT_BITS       = $clog2(NUM_PARTITIONS + 1);

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   typedef logic [IDX_BITS-1:0]       idx_type;
   typedef logic [CNT_BITS-1:0]       cnt_type;
   typedef logic [SIZE_BITS-1:0]      size_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_FIT_POLICY = 1'b0;
   localparam csr_index_type CSR_PARTITIONS = 1'b1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_BEST  = 2'd1,
      POLICY_WORST = 2'd2,
      POLICY_NEXT  = 2'd3
   } policy_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_index;
      size_type wr_cap;
      logic     clr_en;
      idx_type  clr_index;
      idx_type  rd_index;
   } table_cmd_type;

   typedef struct packed {
      size_type cap;
      logic     free;
   } table_rd_type;

   typedef struct packed {
      size_type   cap;
      logic       free;
      size_type   req;
      size_type   best;
      logic       found;
      policy_type policy;
   } fit_req_type;

   typedef struct packed {
      logic     fits;
      logic     take;
      size_type left;
   } fit_rsp_type;

endpackage

// ===== sv/fpfa_table.sv =====
`timescale 1ns / 1ps

module fpfa_table (
   input  logic                   clock,
   input  logic                   reset,
   input  fpfa_pkg::table_cmd_type table_cmd,
   output fpfa_pkg::table_rd_type  table_rd
);

   fpfa_pkg::size_type                        cap_ff [fpfa_pkg::NUM_PARTITIONS];
   logic [fpfa_pkg::NUM_PARTITIONS-1:0]       free_ff;
   logic [fpfa_pkg::NUM_PARTITIONS-1:0]       free_in;

   always_ff @(posedge clock) begin
      if (table_cmd.wr_en) begin
         cap_ff[table_cmd.wr_index] <= table_cmd.wr_cap;
      end
   end

   always_comb begin
      free_in = free_ff;
      if (table_cmd.wr_en) begin
         free_in[table_cmd.wr_index] = 1'b1;
      end
      if (table_cmd.clr_en) begin
         free_in[table_cmd.clr_index] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

   assign table_rd.cap  = cap_ff[table_cmd.rd_index];
   assign table_rd.free = free_ff[table_cmd.rd_index];

endmodule

// ===== sv/fpfa_fit_unit.sv =====
`timescale 1ns / 1ps

module fpfa_fit_unit (
   input  fpfa_pkg::fit_req_type fit_req,
   output fpfa_pkg::fit_rsp_type fit_rsp
);

   logic [fpfa_pkg::SIZE_BITS:0] diff;
   logic                         better;

   always_comb begin
      diff = {1'b0, fit_req.cap} - {1'b0, fit_req.req};
      fit_rsp.left = diff[fpfa_pkg::SIZE_BITS-1:0];
      fit_rsp.fits = fit_req.free & ~diff[fpfa_pkg::SIZE_BITS];
      better = ~fit_req.found
             | ((fit_req.policy == fpfa_pkg::POLICY_BEST) && (fit_rsp.left < fit_req.best))
             | ((fit_req.policy == fpfa_pkg::POLICY_WORST) && (fit_rsp.left > fit_req.best));
      fit_rsp.take = fit_rsp.fits & better;
   end

endmodule

// ===== sv/fpfa_ctrl.sv =====
`timescale 1ns / 1ps

module fpfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic [3:0]              req_partition_index,
   input  logic [15:0]             req_partition_capacity,
   input  logic [15:0]             req_request_size,
   input  fpfa_pkg::policy_type    fit_policy,
   input  fpfa_pkg::cnt_type       scan_limit,
   output fpfa_pkg::table_cmd_type table_cmd,
   input  fpfa_pkg::table_rd_type  table_rd,
   output fpfa_pkg::fit_req_type   fit_req,
   input  fpfa_pkg::fit_rsp_type   fit_rsp,
   output logic                    rsp_strobe,
   output logic                    rsp_granted,
   output logic [3:0]              rsp_granted_partition,
   output logic [15:0]             rsp_leftover
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic               load_ok_ff, load_ok_in;
   fpfa_pkg::idx_type  load_idx_ff, load_idx_in;
   fpfa_pkg::size_type load_cap_ff, load_cap_in;
   fpfa_pkg::size_type req_ff, req_in;
   fpfa_pkg::cnt_type  scan_n_ff, scan_n_in;
   fpfa_pkg::cnt_type  cnt_ff, cnt_in;
   fpfa_pkg::idx_type  idx_ff, idx_in;
   logic               found_ff, found_in;
   fpfa_pkg::idx_type  pick_ff, pick_in;
   fpfa_pkg::size_type best_ff, best_in;
   fpfa_pkg::idx_type  ptr_ff, ptr_in;
   logic               strobe_ff, strobe_in;
   logic               granted_ff, granted_in;
   logic [3:0]         part_ff, part_in;
   logic [15:0]        left_ff, left_in;
   logic               last;
   logic               stop;

   assign busy = (state_ff != ST_IDLE);

   assign fit_req.cap    = table_rd.cap;
   assign fit_req.free   = table_rd.free;
   assign fit_req.req    = req_ff;
   assign fit_req.best   = best_ff;
   assign fit_req.found  = found_ff;
   assign fit_req.policy = fit_policy;

   always_comb begin
      state_in    = state_ff;
      load_ok_in  = load_ok_ff;
      load_idx_in = load_idx_ff;
      load_cap_in = load_cap_ff;
      req_in      = req_ff;
      scan_n_in   = scan_n_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      ptr_in      = ptr_ff;
      strobe_in   = 1'b0;
      granted_in  = granted_ff;
      part_in     = part_ff;
      left_in     = left_ff;
      table_cmd   = '0;
      table_cmd.wr_index  = load_idx_ff;
      table_cmd.wr_cap    = load_cap_ff;
      table_cmd.clr_index = pick_ff;
      table_cmd.rd_index  = idx_ff;
      last = (fpfa_pkg::cnt_type'(cnt_ff + 1'b1) == scan_n_ff);
      stop = fit_rsp.fits
           && ((fit_policy == fpfa_pkg::POLICY_FIRST) || (fit_policy == fpfa_pkg::POLICY_NEXT));

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               load_ok_in  = (32'(req_partition_index) < fpfa_pkg::NUM_PARTITIONS);
               load_idx_in = fpfa_pkg::idx_type'(req_partition_index);
               load_cap_in = fpfa_pkg::size_type'(req_partition_capacity);
               req_in      = fpfa_pkg::size_type'(req_request_size);
               scan_n_in   = scan_limit;
               cnt_in      = '0;
               found_in    = 1'b0;
               pick_in     = '0;
               best_in     = '0;
               if ((fit_policy == fpfa_pkg::POLICY_NEXT)
                   && (fpfa_pkg::cnt_type'(ptr_ff) < scan_limit)) begin
                  idx_in = ptr_ff;
               end else begin
                  idx_in = '0;
               end
               if (req_type == fpfa_pkg::REQ_LOAD) begin
                  state_in = ST_LOAD;
               end else if (scan_limit == '0) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD: begin
            table_cmd.wr_en = load_ok_ff;
            strobe_in  = 1'b1;
            granted_in = 1'b0;
            part_in    = '0;
            left_in    = '0;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            if (fit_rsp.take) begin
               found_in = 1'b1;
               pick_in  = idx_ff;
               best_in  = fit_rsp.left;
            end
            cnt_in = fpfa_pkg::cnt_type'(cnt_ff + 1'b1);
            if (fpfa_pkg::cnt_type'(fpfa_pkg::cnt_type'(idx_ff) + 1'b1) == scan_n_ff) begin
               idx_in = '0;
            end else begin
               idx_in = fpfa_pkg::idx_type'(idx_ff + 1'b1);
            end
            if (last || stop) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            table_cmd.clr_en = found_ff;
            if (found_ff && (fit_policy == fpfa_pkg::POLICY_NEXT)) begin
               ptr_in = pick_ff;
            end
            strobe_in  = 1'b1;
            granted_in = found_ff;
            part_in    = found_ff ? 4'(pick_ff) : 4'd0;
            left_in    = found_ff ? 16'(best_ff) : 16'd0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ok_ff  <= load_ok_in;
      load_idx_ff <= load_idx_in;
      load_cap_ff <= load_cap_in;
      req_ff      <= req_in;
      scan_n_ff   <= scan_n_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      granted_ff  <= granted_in;
      part_ff     <= part_in;
      left_ff     <= left_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_granted           = granted_ff;
   assign rsp_granted_partition = part_ff;
   assign rsp_leftover          = left_ff;

endmodule

// ===== sv/fixed_partition_fit_allocator_core.sv =====
`timescale 1ns / 1ps

// Fixed partition allocator with first, best, worst and next fit policies.
// An item is taken when start is high and busy is low. A load beat writes
// one partition's capacity and marks it free; an allocate beat asks for
// req_request_size and claims a free partition that is large enough.
// Every item gives exactly one result beat on the rsp_ ports, marked by
// rsp_strobe for one cycle; the receiver cannot hold it off.
// A load beat passes through the load state to its result beat. An
// allocate beat scans the partitions in use, one scan state for each:
// the single compare and subtract unit visits one partition per cycle,
// and the commit state then commits the choice. First fit and next fit stop at
// the first hit, so they may end the scan early. Busy falls in the cycle that
// shows the result beat, so a new item is taken at the edge that ends it;
// the block does not take a new item before the last one is through.
// The configuration channel (csr_) writes the fit policy and the partition
// count; it is ready whenever the block is idle.
// Reset marks all partitions free, zeroes the next fit pointer, selects
// first fit with sixteen partitions, and clears any pending result beat.
// Capacities are undefined until loaded.

module fixed_partition_fit_allocator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic [3:0]                            req_partition_index,
   input  logic [15:0]                           req_partition_capacity,
   input  logic [15:0]                           req_request_size,
   output logic                                  rsp_strobe,
   output logic                                  rsp_granted,
   output logic [3:0]                            rsp_granted_partition,
   output logic [15:0]                           rsp_leftover,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fpfa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fpfa_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   fpfa_pkg::policy_type    policy_ff, policy_in;
   logic [4:0]              parts_ff, parts_in;
   fpfa_pkg::cnt_type       scan_limit;
   fpfa_pkg::table_cmd_type table_cmd;
   fpfa_pkg::table_rd_type  table_rd;
   fpfa_pkg::fit_req_type   fit_req;
   fpfa_pkg::fit_rsp_type   fit_rsp;

   assign csr_ready = ~busy;

   always_comb begin
      policy_in = policy_ff;
      parts_in  = parts_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            fpfa_pkg::CSR_FIT_POLICY: begin
               policy_in = fpfa_pkg::policy_type'(csr_wdata[1:0]);
            end
            fpfa_pkg::CSR_PARTITIONS: begin
               parts_in = csr_wdata[4:0];
            end
            default: begin
               parts_in = parts_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fpfa_pkg::POLICY_FIRST;
         parts_ff  <= 5'd16;
      end else begin
         policy_ff <= policy_in;
         parts_ff  <= parts_in;
      end
   end

   assign scan_limit = (32'(parts_ff) > fpfa_pkg::NUM_PARTITIONS)
                     ? fpfa_pkg::cnt_type'(fpfa_pkg::NUM_PARTITIONS)
                     : fpfa_pkg::cnt_type'(parts_ff);

   fpfa_table u_table (
      .clock     (clock),
      .reset     (reset),
      .table_cmd (table_cmd),
      .table_rd  (table_rd)
   );

   fpfa_fit_unit u_fit_unit (
      .fit_req (fit_req),
      .fit_rsp (fit_rsp)
   );

   fpfa_ctrl u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_type               (req_type),
      .req_partition_index    (req_partition_index),
      .req_partition_capacity (req_partition_capacity),
      .req_request_size       (req_request_size),
      .fit_policy             (policy_ff),
      .scan_limit             (scan_limit),
      .table_cmd              (table_cmd),
      .table_rd               (table_rd),
      .fit_req                (fit_req),
      .fit_rsp                (fit_rsp),
      .rsp_strobe             (rsp_strobe),
      .rsp_granted            (rsp_granted),
      .rsp_granted_partition  (rsp_granted_partition),
      .rsp_leftover           (rsp_leftover)
   );

endmodule

// ===== sv/fpfa_checker.sv =====
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_core_defines.svh"

module fpfa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_type,
   input logic [3:0]                          req_partition_index,
   input logic [15:0]                         req_partition_capacity,
   input logic [15:0]                         req_request_size,
   input logic                                rsp_strobe,
   input logic                                rsp_granted,
   input logic [3:0]                          rsp_granted_partition,
   input logic [15:0]                         rsp_leftover,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [fpfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [fpfa_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // A result beat is only shown once the item has finished.
   `FPFA_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // An accepted item always makes the block busy in the cycle after acceptance.
   `FPFA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A refused or load beat carries no partition and no leftover.
   `FPFA_ASSERT_SAME(a_no_grant_zero, clock, reset, rsp_strobe && !rsp_granted,
                     (rsp_granted_partition == 4'd0) && (rsp_leftover == 16'd0))
   // Result beats come only from the load and commit states, which both return to idle, so result beats never touch.
   `FPFA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (.*);
